// File: hdl/pfpp_pkg.sv
// Shared types and constants for the page framebuffer pixel plot unit.
// Holds panel geometry, request and color codes, and the controller state type.
`timescale 1ns / 1ps

package pfpp_pkg;

	// Panel geometry; the store keeps one byte per column per 8-row page.
	localparam int PANEL_WIDTH  = 192;
	localparam int PANEL_HEIGHT = 64;
	localparam int PAGE_ROWS    = 8;
	localparam int PAGE_COUNT   = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
	localparam int STORE_BYTES  = PANEL_WIDTH * PAGE_COUNT;

	// Field widths.
	localparam int IDX_W   = 11;
	localparam int DATA_W  = 8;
	localparam int XY_W    = 10;
	localparam int DIM_W   = 9;
	localparam int COORD_W = $clog2((PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT);
	localparam int ROW_W   = $clog2(PAGE_ROWS);

	// Stream payload widths in whole bytes.
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 24;

	typedef enum logic [1:0] {
		REQ_PLOT  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		COL_CLEAR  = 2'd0,
		COL_SET    = 2'd1,
		COL_INVERT = 2'd2,
		COL_KEEP   = 2'd3
	} colour_t;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_BUSY  = 2'd1,
		ST_CLEAR = 2'd2
	} state_t;

endpackage

// File: hdl/page_framebuffer_pixel_plot_unit.sv
// Page framebuffer pixel plot unit: frame store memory, plot/read/clear control.
// Depends on pfpp_pkg for geometry, codes and the state type.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | tuser: req_type; tdata: plot and read fields
//  m_*     | out       | m_tvalid/m_tready  | tdata: read_data, byte_index, in_bounds
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_data: rotation
//
// Each request runs as the frame store read issued at the transfer, followed by
// modify, write back and load of the output register. A clear request adds a sweep
// through all STORE_BYTES (1536) bytes of the frame store, one byte per cycle.
// After reset the same sweep runs before the first request is taken.
// A new request is taken while a result waits only if that result leaves in the same cycle.

module page_framebuffer_pixel_plot_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [9:0] x_coord, [19:10] y_coord, [21:20] colour_mode, [32:22] read_index
	input  logic [pfpp_pkg::S_TDATA_W-1:0]  s_tdata,
	// [1:0] req_type
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] read_data, [18:8] byte_index, [19] in_bounds
	output logic [pfpp_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_data
);
	import pfpp_pkg::*;

	// Frame store.
	logic [DATA_W-1:0] mem [STORE_BYTES];
	logic [DATA_W-1:0] mem_rdata_q;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;

	state_t state_q, state_d;
	logic [IDX_W-1:0] clr_cnt_q;
	logic [1:0]       rotation_q;

	// Input field views.
	logic [XY_W-1:0]  x_coord, y_coord;
	logic [1:0]       colour_mode;
	logic [IDX_W-1:0] read_index;
	req_t             req_type;

	// Address calculation at the transfer.
	logic [DIM_W-1:0]   log_w, log_h;
	logic               x_ok, y_ok, plot_ok, read_ok;
	logic [COORD_W-1:0] xs, ys, px, py;
	logic [IDX_W-1:0]   plot_idx;
	logic [DATA_W-1:0]  plot_mask;

	// Request held across the read cycle.
	req_t              req_s1;
	logic              plot_ok_s1, read_ok_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [DATA_W-1:0] mask_s1;
	colour_t           colour_s1;

	// Modify and output register.
	logic [DATA_W-1:0] new_byte;
	logic              out_load;
	logic [DATA_W-1:0] out_data_d;
	logic [IDX_W-1:0]  out_idx_d;
	logic              out_inb_d;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] out_data_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_inb_q;
	logic              s_xfer;

	assign x_coord     = s_tdata[XY_W-1:0];
	assign y_coord     = s_tdata[2*XY_W-1:XY_W];
	assign colour_mode = s_tdata[2*XY_W+1:2*XY_W];
	assign read_index  = s_tdata[2*XY_W+2+IDX_W-1:2*XY_W+2];
	assign req_type    = req_t'(s_tuser);

	assign cfg_ready = 1'b1;
	assign s_xfer    = s_tvalid && s_tready;

	// Rotation register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= 2'd0;
		end else if (cfg_valid && cfg_ready) begin
			rotation_q <= cfg_data;
		end
	end

	// Bounds check against the rotated panel and quarter-turn coordinate mapping.
	always_comb begin
		if (rotation_q[0]) begin
			log_w = DIM_W'(PANEL_HEIGHT);
			log_h = DIM_W'(PANEL_WIDTH);
		end else begin
			log_w = DIM_W'(PANEL_WIDTH);
			log_h = DIM_W'(PANEL_HEIGHT);
		end
		x_ok = !x_coord[XY_W-1] && (x_coord[DIM_W-1:0] < log_w);
		y_ok = !y_coord[XY_W-1] && (y_coord[DIM_W-1:0] < log_h);
		xs   = x_coord[COORD_W-1:0];
		ys   = y_coord[COORD_W-1:0];
		unique case (rot_t'(rotation_q))
			ROT_90: begin
				px = COORD_W'(PANEL_WIDTH - 1) - ys;
				py = xs;
			end
			ROT_180: begin
				px = COORD_W'(PANEL_WIDTH - 1) - xs;
				py = COORD_W'(PANEL_HEIGHT - 1) - ys;
			end
			ROT_270: begin
				px = ys;
				py = COORD_W'(PANEL_HEIGHT - 1) - xs;
			end
			default: begin
				px = xs;
				py = ys;
			end
		endcase
		plot_idx  = IDX_W'(py >> ROW_W) * IDX_W'(PANEL_WIDTH) + IDX_W'(px);
		plot_mask = DATA_W'(1) << py[ROW_W-1:0];
		plot_ok   = x_ok && y_ok && ({1'b0, plot_idx} < (IDX_W + 1)'(STORE_BYTES));
		read_ok   = {1'b0, read_index} < (IDX_W + 1)'(STORE_BYTES);
	end

	// Capture the request at the transfer.
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			req_s1     <= req_type;
			plot_ok_s1 <= plot_ok;
			read_ok_s1 <= read_ok;
			idx_s1     <= (req_type == REQ_PLOT) ? plot_idx : read_index;
			mask_s1    <= plot_mask;
			colour_s1  <= colour_t'(colour_mode);
		end
	end

	// Frame store: one write and one registered read per cycle.
	assign mem_raddr = (req_type == REQ_PLOT) ? plot_idx : read_index;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	// Bit update of the fetched byte.
	always_comb begin
		unique case (colour_s1)
			COL_CLEAR:  new_byte = mem_rdata_q & ~mask_s1;
			COL_SET:    new_byte = mem_rdata_q | mask_s1;
			COL_INVERT: new_byte = mem_rdata_q ^ mask_s1;
			default:    new_byte = mem_rdata_q;
		endcase
	end

	// Controller: next state, write port and output load.
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = idx_s1;
		mem_wdata  = new_byte;
		out_load   = 1'b0;
		out_data_d = '0;
		out_idx_d  = '0;
		out_inb_d  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = !m_tvalid_q || m_tready;
				if (s_xfer) begin
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				out_load = 1'b1;
				state_d  = ST_IDLE;
				unique case (req_s1)
					REQ_PLOT: begin
						if (plot_ok_s1) begin
							mem_we     = 1'b1;
							out_data_d = new_byte;
							out_idx_d  = idx_s1;
							out_inb_d  = 1'b1;
						end
					end
					REQ_READ: begin
						out_data_d = read_ok_s1 ? mem_rdata_q : '0;
						out_idx_d  = idx_s1;
					end
					REQ_CLEAR: begin
						state_d = ST_CLEAR;
					end
					default: begin
					end
				endcase
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
				if (clr_cnt_q == IDX_W'(STORE_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and clearing sweep counter; reset starts with a sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= (state_d == ST_IDLE) ? '0 : clr_cnt_q + IDX_W'(1);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_data_d;
			out_idx_q  <= out_idx_d;
			out_inb_q  <= out_inb_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(M_TDATA_W - DATA_W - IDX_W - 1)'(0), out_inb_q, out_idx_q, out_data_q};

	// A result is only loaded into an empty output register.
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !m_tvalid_q)
		else $error("output register loaded while a result was pending");

	// Each accepted request is followed by its modify cycle.
	a_xfer_to_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> (state_q == ST_BUSY))
		else $error("accepted request did not enter the modify cycle");

	// The store is only written back for an in-bounds plot outside a sweep.
	a_write_only_plot: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && state_q != ST_CLEAR) |-> (req_s1 == REQ_PLOT && plot_ok_s1))
		else $error("frame store written for a request that must not modify it");

	// The sweep counter stays within the store.
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, clr_cnt_q} < (IDX_W + 1)'(STORE_BYTES))
		else $error("clearing sweep ran past the end of the store");

endmodule

// File: test/page_framebuffer_pixel_plot_unit_tb.sv
// Self-checking testbench for the page framebuffer pixel plot unit.
// Plots, reads, clears and rotation changes are checked against a behavioral copy of the store.
// Depends on pfpp_pkg and page_framebuffer_pixel_plot_unit.
`timescale 1ns / 1ps

module page_framebuffer_pixel_plot_unit_tb;

	import pfpp_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 1600;	// covers a full clear sweep of the store
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 120;	// per rotation, per idling phase
	localparam int REPORT_LIMIT  = 10;

	// One result transfer, laid out as on m_tdata from bit 0 up.
	typedef struct packed {
		logic              in_bounds;
		logic [IDX_W-1:0]  byte_index;
		logic [DATA_W-1:0] read_data;
	} pixel_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_data = '0;

	// Behavioral copy of the store and the rotation register.
	logic [DATA_W-1:0] frame_copy [STORE_BYTES];
	rot_t              plot_rotation = ROT_0;
	logic [IDX_W-1:0]  last_plot_index = '0;

	pixel_result_t awaited_results [$];
	pixel_result_t got_result, want_result;
	int            mismatch_count = 0;
	int unsigned   cycle_count = 0;

	// Idling percentages and the long receiver hold-off request.
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int unsigned hold_serial = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	page_framebuffer_pixel_plot_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (hold_seen != hold_serial) begin
			hold_seen <= hold_serial;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Result checker: each transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_result = pixel_result_t'(m_tdata[$bits(pixel_result_t)-1:0]);
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("Unexpected result: data %02h index %0d in_bounds %0b",
						got_result.read_data, got_result.byte_index, got_result.in_bounds);
			end else begin
				want_result = awaited_results.pop_front();
				if (got_result.read_data !== want_result.read_data ||
					got_result.byte_index !== want_result.byte_index ||
					got_result.in_bounds !== want_result.in_bounds) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("Mismatch at %0t: expected data %02h index %0d in_bounds %0b, %s",
							$realtime, want_result.read_data, want_result.byte_index,
							want_result.in_bounds,
							$sformatf("got data %02h index %0d in_bounds %0b",
								got_result.read_data, got_result.byte_index,
								got_result.in_bounds));
				end
			end
		end
	end

	function automatic int logical_width();
		return (plot_rotation == ROT_90 || plot_rotation == ROT_270) ? PANEL_HEIGHT : PANEL_WIDTH;
	endfunction

	function automatic int logical_height();
		return (plot_rotation == ROT_90 || plot_rotation == ROT_270) ? PANEL_WIDTH : PANEL_HEIGHT;
	endfunction

	// Applies one request to the store copy and returns the result it should produce.
	function automatic pixel_result_t apply_to_frame(req_t kind, logic signed [XY_W-1:0] x,
		logic signed [XY_W-1:0] y, colour_t mode, logic [IDX_W-1:0] read_index);
		pixel_result_t     res;
		int                xi, yi, px, py, idx;
		logic [DATA_W-1:0] mask;
		res = '0;
		xi = x;
		yi = y;
		case (kind)
			REQ_PLOT: begin
				if (xi >= 0 && xi < logical_width() && yi >= 0 && yi < logical_height()) begin
					case (plot_rotation)
						ROT_90: begin
							px = PANEL_WIDTH - 1 - yi;
							py = xi;
						end
						ROT_180: begin
							px = PANEL_WIDTH - 1 - xi;
							py = PANEL_HEIGHT - 1 - yi;
						end
						ROT_270: begin
							px = yi;
							py = PANEL_HEIGHT - 1 - xi;
						end
						default: begin
							px = xi;
							py = yi;
						end
					endcase
					idx = (py / PAGE_ROWS) * PANEL_WIDTH + px;
					if (idx < STORE_BYTES) begin
						mask = DATA_W'(1 << (py % PAGE_ROWS));
						case (mode)
							COL_CLEAR:  frame_copy[idx] = frame_copy[idx] & ~mask;
							COL_SET:    frame_copy[idx] = frame_copy[idx] | mask;
							COL_INVERT: frame_copy[idx] = frame_copy[idx] ^ mask;
							default:    ;
						endcase
						res.read_data  = frame_copy[idx];
						res.byte_index = IDX_W'(idx);
						res.in_bounds  = 1'b1;
						last_plot_index = IDX_W'(idx);
					end
				end
			end
			REQ_READ: begin
				res.byte_index = read_index;
				if (read_index < STORE_BYTES)
					res.read_data = frame_copy[read_index];
			end
			REQ_CLEAR: begin
				foreach (frame_copy[i])
					frame_copy[i] = '0;
			end
			default: ;
		endcase
		return res;
	endfunction

	// Offers one request, waits for its transfer and records the expected result.
	// The valid line stays high on return so that back-to-back requests need no gap.
	task automatic send_request(req_t kind, logic signed [XY_W-1:0] x,
		logic signed [XY_W-1:0] y, colour_t mode, logic [IDX_W-1:0] read_index);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(S_TDATA_W - 33){1'b0}}, read_index, mode, y, x};
		do @(posedge clk); while (!s_tready);
		awaited_results.push_back(apply_to_frame(kind, x, y, mode, read_index));
	endtask

	// Stops offering requests and waits until every result is in and the block is quiet.
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rotation(rot_t value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		plot_rotation = value;
	endtask

	// Mostly in-bounds plots with edge and wild coordinates mixed in, reads that
	// often revisit the byte just plotted, and rare clears and unknown requests.
	task automatic send_random_request();
		int                      pick, lw, lh;
		req_t                    kind;
		logic signed [XY_W-1:0]  xc, yc;
		logic [IDX_W-1:0]        read_index;
		lw = logical_width();
		lh = logical_height();
		xc = XY_W'($urandom);
		yc = XY_W'($urandom);
		read_index = IDX_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 78) begin
			kind = REQ_PLOT;
			case ($urandom_range(0, 9))
				0: ;
				1: begin
					xc = XY_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 1) - 1
						: lw - 1 + $urandom_range(0, 1));
					yc = XY_W'($urandom_range(0, lh - 1));
				end
				2: begin
					xc = XY_W'($urandom_range(0, lw - 1));
					yc = XY_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 1) - 1
						: lh - 1 + $urandom_range(0, 1));
				end
				default: begin
					xc = XY_W'($urandom_range(0, lw - 1));
					yc = XY_W'($urandom_range(0, lh - 1));
				end
			endcase
		end else if (pick < 96) begin
			kind = REQ_READ;
			case ($urandom_range(0, 9))
				0:       ;
				1, 2, 3: read_index = IDX_W'($urandom_range(0, STORE_BYTES - 1));
				default: read_index = last_plot_index;
			endcase
		end else if (pick < 97) begin
			kind = REQ_CLEAR;
		end else begin
			kind = REQ_NONE;
		end
		send_request(kind, xc, yc, colour_t'($urandom_range(0, 3)), read_index);
	endtask

	// Directed cases at the reset rotation: corners, every color mode, bounds,
	// reads past the store, unknown request and clear.
	task automatic test_directed_edges();
		send_request(REQ_PLOT, 10'sd0, 10'sd0, COL_SET, '0);
		send_request(REQ_PLOT, 10'sd191, 10'sd63, COL_SET, '0);
		send_request(REQ_PLOT, 10'sd0, 10'sd7, COL_INVERT, '0);
		send_request(REQ_PLOT, 10'sd0, 10'sd0, COL_INVERT, '0);
		send_request(REQ_PLOT, 10'sd0, 10'sd7, COL_KEEP, '0);
		send_request(REQ_PLOT, 10'sd0, 10'sd7, COL_CLEAR, '0);
		send_request(REQ_PLOT, 10'sd5, 10'sd9, COL_SET, '0);
		send_request(REQ_PLOT, -10'sd1, 10'sd0, COL_SET, '0);
		send_request(REQ_PLOT, 10'sd192, 10'sd0, COL_SET, '0);
		send_request(REQ_PLOT, 10'sd0, 10'sd64, COL_SET, '0);
		send_request(REQ_PLOT, -10'sd512, -10'sd512, COL_SET, '0);
		send_request(REQ_PLOT, 10'sd511, 10'sd511, COL_INVERT, '1);
		send_request(REQ_PLOT, 10'sd0, -10'sd1, COL_SET, '0);
		send_request(REQ_READ, '0, '0, COL_CLEAR, 11'd0);
		send_request(REQ_READ, '1, '1, COL_KEEP, 11'd1535);
		send_request(REQ_READ, '0, '0, COL_CLEAR, 11'd1536);
		send_request(REQ_READ, '0, '0, COL_CLEAR, 11'd2047);
		send_request(REQ_READ, '0, '0, COL_CLEAR, 11'd197);
		send_request(REQ_NONE, 10'sd3, 10'sd3, COL_SET, 11'd197);
		send_request(REQ_CLEAR, 10'sd3, 10'sd3, COL_SET, 11'd197);
		send_request(REQ_READ, '0, '0, COL_CLEAR, 11'd1535);
		send_request(REQ_READ, '0, '0, COL_CLEAR, 11'd197);
		send_request(REQ_PLOT, 10'sd191, 10'sd0, COL_KEEP, '0);
	endtask

	// Each rotation in turn: corner plots of the rotated panel, then random traffic.
	task automatic test_rotation_sweep();
		rot_t order [4] = '{ROT_270, ROT_90, ROT_180, ROT_0};
		foreach (order[i]) begin
			settle_idle();
			write_rotation(order[i]);
			send_request(REQ_PLOT, 10'sd0, 10'sd0, COL_SET, '0);
			send_request(REQ_PLOT, XY_W'(logical_width() - 1), 10'sd0, COL_INVERT, '0);
			send_request(REQ_PLOT, 10'sd0, XY_W'(logical_height() - 1), COL_SET, '0);
			send_request(REQ_PLOT, XY_W'(logical_width() - 1), XY_W'(logical_height() - 1),
				COL_INVERT, '0);
			repeat (RANDOM_ITEMS) send_random_request();
		end
	endtask

	// Long receiver hold-off while requests keep coming, so the input backs up.
	task automatic test_output_backpressure();
		hold_serial <= hold_serial + 1;
		repeat (40) send_random_request();
	endtask

	initial begin
		// The store copy starts out cleared, as the block's store does after reset.
		foreach (frame_copy[i])
			frame_copy[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct  = 28;
		recv_stall_pct = 73;
		test_directed_edges();
		test_rotation_sweep();

		send_idle_pct  = 73;
		recv_stall_pct = 28;
		test_rotation_sweep();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_rotation_sweep();
		test_output_backpressure();

		settle_idle();
		if (mismatch_count == 0 && awaited_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
